/* src/ast_pkg.sv */
// Shared constants, character codes and byte classifiers for the assembly
// source tokenizer. No dependencies.
package ast_pkg;

  localparam int unsigned POSITION_BITS_DEF = 20;
  localparam int unsigned LINE_BITS_DEF     = 16;
  localparam int unsigned CFG_W             = 16;
  localparam int unsigned KIND_W            = 5;
  localparam int unsigned RQ_DEPTH          = 4;

  localparam logic [CFG_W-1:0] FIRST_LINE_RST = 16'd1;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_LBRACK   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_RBRACK   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_DOT      = 5'd5;
  localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd7;
  localparam logic [KIND_W-1:0] KIND_COLON    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd9;
  localparam logic [KIND_W-1:0] KIND_SLASH    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_PERCENT  = 5'd11;
  localparam logic [KIND_W-1:0] KIND_DOLLAR   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_HEX      = 5'd13;
  localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd14;
  localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_COMMENT  = 5'd16;
  localparam logic [KIND_W-1:0] KIND_EOF      = 5'd17;

  // character codes
  localparam logic [7:0] CH_H       = 8'h68;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_US      = 8'h5f;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_RBRACK  = 8'h5d;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SEMI    = 8'h3b;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } punct_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) || (c == CH_US);
  endfunction

  function automatic punct_t punct_lookup(input logic [7:0] c);
    punct_t r;
    r.hit  = 1'b1;
    r.kind = KIND_LPAREN;
    case (c)
      CH_LPAREN:  r.kind = KIND_LPAREN;
      CH_RPAREN:  r.kind = KIND_RPAREN;
      CH_LBRACK:  r.kind = KIND_LBRACK;
      CH_RBRACK:  r.kind = KIND_RBRACK;
      CH_COMMA:   r.kind = KIND_COMMA;
      CH_DOT:     r.kind = KIND_DOT;
      CH_MINUS:   r.kind = KIND_MINUS;
      CH_PLUS:    r.kind = KIND_PLUS;
      CH_COLON:   r.kind = KIND_COLON;
      CH_SEMI:    r.kind = KIND_SEMI;
      CH_PERCENT: r.kind = KIND_PERCENT;
      CH_DOLLAR:  r.kind = KIND_DOLLAR;
      default:    r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/ast_scan.sv */
// Scanner core: mode, lexeme start, byte position and line counter, plus
// the logic that turns one item into up to two packed results. Uses ast_pkg.
module ast_scan
  import ast_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LINE_BITS     = LINE_BITS_DEF,
  localparam int unsigned RES_W        = KIND_W + 2 * POSITION_BITS + LINE_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic                 eof_i,
  input  logic [7:0]           byte_i,
  input  logic [LINE_BITS-1:0] first_line_i,
  output logic [1:0]           emit_num_o,
  output logic [RES_W-1:0]     res0_o,
  output logic [RES_W-1:0]     res1_o
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_IDENT   = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_e;

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]     line_q, line_d;

  logic [POSITION_BITS-1:0] span;
  logic                     pend_hit, sec_hit, fresh;
  logic [KIND_W-1:0]        pend_kind, sec_kind;
  logic [POSITION_BITS-1:0] pend_len, sec_off, sec_len;
  punct_t                   pk;
  logic [RES_W-1:0]         pend_word, sec_word;

  assign span = (pos_q >= start_q) ? (pos_q - start_q) : '0;
  assign pk   = punct_lookup(byte_i);

  always_comb begin
    mode_d    = mode_q;
    start_d   = start_q;
    pos_d     = (pos_q != '1) ? (pos_q + POSITION_BITS'(1)) : pos_q;
    line_d    = line_q;
    pend_hit  = 1'b0;
    pend_kind = KIND_NUMBER;
    pend_len  = span;
    sec_hit   = 1'b0;
    sec_kind  = pk.kind;
    sec_off   = pos_q;
    sec_len   = POSITION_BITS'(1);
    fresh     = 1'b0;

    if (eof_i) begin
      unique case (mode_q)
        MODE_SLASH:   begin pend_hit = 1'b1; pend_kind = KIND_SLASH;   end
        MODE_NUMBER:  begin pend_hit = 1'b1; pend_kind = KIND_NUMBER;  end
        MODE_IDENT:   begin pend_hit = 1'b1; pend_kind = KIND_IDENT;   end
        MODE_COMMENT: begin pend_hit = 1'b1; pend_kind = KIND_COMMENT; end
        default:      pend_hit = 1'b0;
      endcase
      sec_hit  = 1'b1;
      sec_kind = KIND_EOF;
      sec_len  = '0;
      mode_d   = MODE_IDLE;
      start_d  = '0;
      pos_d    = '0;
      line_d   = first_line_i;
    end else begin
      unique case (mode_q)
        MODE_SLASH: begin
          if (byte_i == CH_SLASH) begin
            mode_d = MODE_COMMENT;
          end else begin
            pend_hit  = 1'b1;
            pend_kind = KIND_SLASH;
            fresh     = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (byte_i == CH_H) begin
            // suffix belongs to the token and is consumed here
            pend_hit  = 1'b1;
            pend_kind = KIND_HEX;
            pend_len  = span + POSITION_BITS'(1);
            mode_d    = MODE_IDLE;
          end else if (!is_digit(byte_i)) begin
            pend_hit  = 1'b1;
            pend_kind = KIND_NUMBER;
            fresh     = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (!(is_alpha(byte_i) || is_digit(byte_i))) begin
            pend_hit  = 1'b1;
            pend_kind = KIND_IDENT;
            fresh     = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (byte_i == CH_NL) begin
            pend_hit  = 1'b1;
            pend_kind = KIND_COMMENT;
            fresh     = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        mode_d = MODE_IDLE;
        if (pk.hit) begin
          sec_hit = 1'b1;
        end else if (byte_i == CH_SLASH) begin
          mode_d  = MODE_SLASH;
          start_d = pos_q;
        end else if (byte_i == CH_NL) begin
          if (line_q != '1) line_d = line_q + LINE_BITS'(1);
        end else if (is_digit(byte_i)) begin
          mode_d  = MODE_NUMBER;
          start_d = pos_q;
        end else if (is_alpha(byte_i)) begin
          mode_d  = MODE_IDENT;
          start_d = pos_q;
        end
      end
    end
  end

  // every result of an item carries the line count from before the item
  assign pend_word = {pend_kind, start_q, pend_len, line_q, !sec_hit};
  assign sec_word  = {sec_kind, sec_off, sec_len, line_q, 1'b1};

  assign emit_num_o = acc_i ? (2'(pend_hit) + 2'(sec_hit)) : 2'd0;
  assign res0_o     = pend_hit ? pend_word : sec_word;
  assign res1_o     = sec_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= LINE_BITS'(FIRST_LINE_RST);
    end else if (acc_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

  a_eof_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && eof_i) |-> (emit_num_o != 2'd0))
    else $error("end of input produced no result");

  a_eof_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && eof_i) |=> (pos_q == '0 && mode_q == MODE_IDLE && line_q == $past(first_line_i)))
    else $error("stream did not restart after end of input");

  a_pos_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && !eof_i) |=> (pos_q >= $past(pos_q)))
    else $error("byte position went backwards");

endmodule

/* src/ast_rq.sv */
// Result queue: small circular buffer that takes up to two results per
// cycle and hands out one per cycle. Uses ast_pkg for its depth.
module ast_rq
  import ast_pkg::*;
#(
  parameter int unsigned DW = 62
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_num_i,
  input  logic [DW-1:0] push0_i,
  input  logic [DW-1:0] push1_i,
  input  logic          pop_i,
  output logic [DW-1:0] head_o,
  output logic          valid_o,
  output logic          space_o
);

  localparam int unsigned PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(RQ_DEPTH + 1);

  logic [DW-1:0]    mem_q [RQ_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic [PTR_W-1:0] wptr_nx;

  assign wptr_nx = wptr_q + PTR_W'(1);
  assign head_o  = mem_q[rptr_q];
  assign valid_o = (count_q != '0);
  // room for the worst case of two results
  assign space_o = (count_q <= CNT_W'(RQ_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) mem_q[wptr_q] <= push0_i;
    if (push_num_i == 2'd2) mem_q[wptr_nx] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PTR_W'(push_num_i);
      if (pop_i) rptr_q <= rptr_q + PTR_W'(1);
      count_q <= count_q + CNT_W'(push_num_i) - CNT_W'(pop_i);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num_i != 2'd0) |-> (count_q + CNT_W'(push_num_i) <= CNT_W'(RQ_DEPTH)))
    else $error("result queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty result queue");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && push_num_i == 2'd0) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("result count did not drop on pop");

endmodule

/* src/assembly_source_tokenizer_core.sv */
// Tokens of an accepted item are written into the result queue and offered at the output in order.
// Throughput: one item per cycle; results leave one per cycle while the receiver does not
// stall, so the two tokens of one item leave one after the other. The input stalls while the
// four-entry result queue has fewer than two free slots.
// Reset: mode idle, positions zero, queue empty, first line number and line
// counter set to 1.
module assembly_source_tokenizer_core
  import ast_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LINE_BITS     = LINE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [7:0]               source_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [KIND_W-1:0]        token_kind_o,
  output logic [POSITION_BITS-1:0] token_offset_o,
  output logic [POSITION_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]     token_line_o,
  output logic                     run_last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned RES_W = KIND_W + 2 * POSITION_BITS + LINE_BITS + 1;

  logic [CFG_W-1:0] first_line_q;
  logic             acc, space, pop;
  logic [1:0]       emit_num;
  logic [RES_W-1:0] res0, res1, head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !space;
  assign acc         = in_valid_i && space;
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q <= FIRST_LINE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      first_line_q <= cfg_data_i;
    end
  end

  ast_scan #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .eof_i       (req_type_i),
    .byte_i      (source_byte_i),
    .first_line_i(LINE_BITS'(first_line_q)),
    .emit_num_o  (emit_num),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  ast_rq #(
    .DW(RES_W)
  ) u_rq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_num_i(emit_num),
    .push0_i   (res0),
    .push1_i   (res1),
    .pop_i     (pop),
    .head_o    (head),
    .valid_o   (out_valid_o),
    .space_o   (space)
  );

  assign {token_kind_o, token_offset_o, token_length_o, token_line_o, run_last_o} = head;

endmodule

/* dv/assembly_source_tokenizer_core_tb.sv */
// Self-checking testbench for assembly_source_tokenizer_core: directed table, then phases of
// random token-shaped byte streams, each result checked against a tokenizer predictor.
// Depends on ast_pkg and the core RTL.
module assembly_source_tokenizer_core_tb;
  import ast_pkg::*;

  localparam int unsigned POS_W       = POSITION_BITS_DEF;
  localparam int unsigned LINE_W      = LINE_BITS_DEF;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 125;
  localparam int          NUM_PHASES  = 5;
  localparam int          NUM_ROWS    = 25;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOF  = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [7:0] PUNCT_BYTES [12] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
    CH_COMMA, CH_DOT, CH_MINUS, CH_PLUS, CH_COLON, CH_SEMI, CH_PERCENT, CH_DOLLAR};

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_SLASH, SCAN_NUMBER, SCAN_IDENT, SCAN_COMMENT
  } scan_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  len;
    logic [LINE_W-1:0] tok_line;
    logic              last;
  } token_t;

  typedef struct packed {
    logic              req;
    logic [7:0]        ch;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  offset;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic              in_req_type;
  logic [7:0]        in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [KIND_W-1:0] out_kind;
  logic [POS_W-1:0]  out_offset;
  logic [POS_W-1:0]  out_length;
  logic [LINE_W-1:0] out_line;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;

  assembly_source_tokenizer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (in_req_type),
    .source_byte_i (in_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .token_kind_o  (out_kind),
    .token_offset_o(out_offset),
    .token_length_o(out_length),
    .token_line_o  (out_line),
    .run_last_o    (out_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // expected tokens in arrival order, and the tokens of the item just scanned
  token_t token_q[$];
  token_t item_tokens[$];

  // predictor state
  scan_mode_e        mode;
  logic [POS_W-1:0]  lex_start;
  logic [POS_W-1:0]  next_pos;
  logic [LINE_W-1:0] line_cnt;
  logic [CFG_W-1:0]  first_line;

  int mismatches;
  int burst_left;
  int quiet_cycles;
  int rx_tick;
  int rx_mode;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic digit_byte(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic word_byte(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_US);
  endfunction

  // {hit, kind}
  function automatic logic [KIND_W:0] punct_code(input logic [7:0] c);
    case (c)
      CH_LPAREN:  return {1'b1, KIND_LPAREN};
      CH_RPAREN:  return {1'b1, KIND_RPAREN};
      CH_LBRACK:  return {1'b1, KIND_LBRACK};
      CH_RBRACK:  return {1'b1, KIND_RBRACK};
      CH_COMMA:   return {1'b1, KIND_COMMA};
      CH_DOT:     return {1'b1, KIND_DOT};
      CH_MINUS:   return {1'b1, KIND_MINUS};
      CH_PLUS:    return {1'b1, KIND_PLUS};
      CH_COLON:   return {1'b1, KIND_COLON};
      CH_SEMI:    return {1'b1, KIND_SEMI};
      CH_PERCENT: return {1'b1, KIND_PERCENT};
      CH_DOLLAR:  return {1'b1, KIND_DOLLAR};
      default:    return '0;
    endcase
  endfunction

  function automatic void emit_token(input logic [KIND_W-1:0] kind,
                                     input logic [POS_W-1:0] off, input logic [POS_W-1:0] len);
    token_t t;
    t = '{kind: kind, offset: off, len: len, tok_line: line_cnt, last: 1'b0};
    item_tokens.insert(item_tokens.size(), t);
  endfunction

  function automatic logic [POS_W-1:0] lexeme_span(input logic [POS_W-1:0] stop);
    return (stop >= lex_start) ? stop - lex_start : '0;
  endfunction

  // byte handled as if the scanner were idle
  function automatic void restart_at(input logic [7:0] c, input logic [POS_W-1:0] p);
    logic [KIND_W:0] pc;
    pc   = punct_code(c);
    mode = SCAN_IDLE;
    if (pc[KIND_W]) begin
      emit_token(pc[KIND_W-1:0], p, POS_W'(1));
    end else if (c == CH_SLASH) begin
      mode      = SCAN_SLASH;
      lex_start = p;
    end else if (c == CH_NL) begin
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
    end else if (digit_byte(c)) begin
      mode      = SCAN_NUMBER;
      lex_start = p;
    end else if (word_byte(c)) begin
      mode      = SCAN_IDENT;
      lex_start = p;
    end
  endfunction

  function automatic void scan_item(input logic req, input logic [7:0] c);
    logic [POS_W-1:0] p;
    token_t           t;
    p = next_pos;
    item_tokens.delete();
    if (req == REQ_EOF) begin
      case (mode)
        SCAN_SLASH:   emit_token(KIND_SLASH, lex_start, lexeme_span(p));
        SCAN_NUMBER:  emit_token(KIND_NUMBER, lex_start, lexeme_span(p));
        SCAN_IDENT:   emit_token(KIND_IDENT, lex_start, lexeme_span(p));
        SCAN_COMMENT: emit_token(KIND_COMMENT, lex_start, lexeme_span(p));
        default: ;
      endcase
      emit_token(KIND_EOF, p, '0);
      mode      = SCAN_IDLE;
      lex_start = '0;
      next_pos  = '0;
      line_cnt  = first_line;
    end else begin
      case (mode)
        SCAN_SLASH: begin
          if (c == CH_SLASH) begin
            mode = SCAN_COMMENT;
          end else begin
            emit_token(KIND_SLASH, lex_start, lexeme_span(p));
            restart_at(c, p);
          end
        end
        SCAN_NUMBER: begin
          if (digit_byte(c)) begin
            // run continues
          end else if (c == CH_H) begin
            // the suffix belongs to the token
            emit_token(KIND_HEX, lex_start, lexeme_span(p) + 1'b1);
            mode = SCAN_IDLE;
          end else begin
            emit_token(KIND_NUMBER, lex_start, lexeme_span(p));
            restart_at(c, p);
          end
        end
        SCAN_IDENT: begin
          if (!(word_byte(c) || digit_byte(c))) begin
            emit_token(KIND_IDENT, lex_start, lexeme_span(p));
            restart_at(c, p);
          end
        end
        SCAN_COMMENT: begin
          if (c == CH_NL) begin
            emit_token(KIND_COMMENT, lex_start, lexeme_span(p));
            restart_at(c, p);
          end
        end
        default: restart_at(c, p);
      endcase
      if (next_pos != '1) next_pos = next_pos + 1'b1;
    end
    if (item_tokens.size() > 0) begin
      t      = item_tokens.pop_back();
      t.last = 1'b1;
      item_tokens.insert(item_tokens.size(), t);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // output side: compare each accepted token with the oldest expectation
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token, expected none, actual kind %0d offset %0d", $time,
                 out_kind, out_offset);
      end else begin
        want = token_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("offset", 32'(want.offset), 32'(out_offset));
        check_field("length", 32'(want.len), 32'(out_length));
        check_field("line", 32'(want.tok_line), 32'(out_line));
        check_field("run_last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // receiver stall pattern: a mode drawn at random picks no, light, heavy or periodic stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ((rx_tick % 16) < 10);
      endcase
    end
  end

  // watchdog on cycles where no channel moves anything
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(input logic req, input logic [7:0] c, input logic typed,
                           input token_t typed_tok);
    int gap;
    @(negedge clk_i);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_byte     <= c;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    scan_item(req, c);
    if (typed) token_q.insert(token_q.size(), typed_tok);
    else foreach (item_tokens[i]) token_q.insert(token_q.size(), item_tokens[i]);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item(REQ_BYTE, c, 1'b0, '0);
  endtask

  task automatic send_eof();
    send_item(REQ_EOF, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // one token-shaped fragment, an end of input, or a blank or noise byte; every item sent is counted
  task automatic send_fragment(inout int count);
    int         sel;
    int         n;
    int         r;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      send_eof();
      count++;
    end else if (sel < 20) begin
      r = $urandom_range(0, 52);
      c = (r < 26) ? 8'("a" + r) : (r < 52) ? 8'("A" + r - 26) : CH_US;
      send_byte(c);
      n = $urandom_range(0, 6);
      repeat (n) begin
        r = $urandom_range(0, 62);
        c = (r < 26) ? 8'("a" + r) : (r < 52) ? 8'("A" + r - 26) :
            (r < 62) ? 8'("0" + r - 52) : CH_US;
        send_byte(c);
      end
      count += n + 1;
    end else if (sel < 35) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
      count += n;
      if ($urandom_range(0, 1)) begin
        send_byte(CH_H);
        count++;
      end
    end else if (sel < 47) begin
      send_byte(CH_SLASH);
      send_byte(CH_SLASH);
      n = $urandom_range(0, 8);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      count += n + 2;
      // some comments stay open until a later newline or end of input
      if ($urandom_range(0, 3) != 0) begin
        send_byte(CH_NL);
        count++;
      end
    end else if (sel < 52) begin
      send_byte(CH_SLASH);
      count++;
    end else if (sel < 72) begin
      send_byte(PUNCT_BYTES[$urandom_range(0, 11)]);
      count++;
    end else if (sel < 80) begin
      send_byte(CH_NL);
      count++;
    end else if (sel < 90) begin
      r = $urandom_range(0, 2);
      send_byte((r == 0) ? CH_SPACE : (r == 1) ? CH_TAB : CH_CR);
      count++;
    end else begin
      send_byte(8'($urandom_range(0, 255)));
      count++;
    end
  endtask

  task automatic write_first_line(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    first_line = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // drain: input quiet, then wait until every expected token has been seen
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    dir_row_t         dir_rows [NUM_ROWS];
    logic [CFG_W-1:0] phase_cfg [NUM_PHASES];
    token_t           tok;
    int               count;

    in_valid     = 1'b0;
    in_req_type  = REQ_BYTE;
    in_byte      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    mismatches   = 0;
    burst_left   = 1;
    quiet_cycles = 0;
    rx_tick      = 0;
    rx_mode      = 0;
    mode         = SCAN_IDLE;
    lex_start    = '0;
    next_pos     = '0;
    first_line   = FIRST_LINE_RST;
    line_cnt     = FIRST_LINE_RST;

    // punctuation rows right after reset are one-byte tokens at offsets 0..11 on line 1
    dir_rows[0]  = '{REQ_BYTE, CH_LPAREN,  1'b1, KIND_LPAREN,  20'd0};
    dir_rows[1]  = '{REQ_BYTE, CH_RPAREN,  1'b1, KIND_RPAREN,  20'd1};
    dir_rows[2]  = '{REQ_BYTE, CH_LBRACK,  1'b1, KIND_LBRACK,  20'd2};
    dir_rows[3]  = '{REQ_BYTE, CH_RBRACK,  1'b1, KIND_RBRACK,  20'd3};
    dir_rows[4]  = '{REQ_BYTE, CH_COMMA,   1'b1, KIND_COMMA,   20'd4};
    dir_rows[5]  = '{REQ_BYTE, CH_DOT,     1'b1, KIND_DOT,     20'd5};
    dir_rows[6]  = '{REQ_BYTE, CH_MINUS,   1'b1, KIND_MINUS,   20'd6};
    dir_rows[7]  = '{REQ_BYTE, CH_PLUS,    1'b1, KIND_PLUS,    20'd7};
    dir_rows[8]  = '{REQ_BYTE, CH_COLON,   1'b1, KIND_COLON,   20'd8};
    dir_rows[9]  = '{REQ_BYTE, CH_SEMI,    1'b1, KIND_SEMI,    20'd9};
    dir_rows[10] = '{REQ_BYTE, CH_PERCENT, 1'b1, KIND_PERCENT, 20'd10};
    dir_rows[11] = '{REQ_BYTE, CH_DOLLAR,  1'b1, KIND_DOLLAR,  20'd11};
    // lone slash ended by a digit, then a hex run closed by its suffix
    dir_rows[12] = '{REQ_BYTE, CH_SLASH,   1'b0, '0, '0};
    dir_rows[13] = '{REQ_BYTE, 8'h39,      1'b0, '0, '0};
    dir_rows[14] = '{REQ_BYTE, CH_H,       1'b0, '0, '0};
    // number ended by an unknown byte
    dir_rows[15] = '{REQ_BYTE, 8'h30,      1'b0, '0, '0};
    dir_rows[16] = '{REQ_BYTE, 8'hff,      1'b0, '0, '0};
    // identifier ended by a slash that opens a comment
    dir_rows[17] = '{REQ_BYTE, CH_US,      1'b0, '0, '0};
    dir_rows[18] = '{REQ_BYTE, 8'h7a,      1'b0, '0, '0};
    dir_rows[19] = '{REQ_BYTE, CH_SLASH,   1'b0, '0, '0};
    dir_rows[20] = '{REQ_BYTE, CH_SLASH,   1'b0, '0, '0};
    dir_rows[21] = '{REQ_BYTE, 8'h00,      1'b0, '0, '0};
    dir_rows[22] = '{REQ_BYTE, CH_NL,      1'b0, '0, '0};
    // pending identifier flushed by end of input
    dir_rows[23] = '{REQ_BYTE, 8'h41,      1'b0, '0, '0};
    dir_rows[24] = '{REQ_EOF,  8'h00,      1'b0, '0, '0};

    phase_cfg[0] = '0;
    phase_cfg[1] = '1;
    phase_cfg[2] = 16'hfffe;
    phase_cfg[3] = 16'($urandom_range(0, 65535));
    phase_cfg[4] = FIRST_LINE_RST;

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      tok = '{kind: dir_rows[i].kind, offset: dir_rows[i].offset, len: 20'd1,
              tok_line: FIRST_LINE_RST, last: 1'b1};
      send_item(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].typed, tok);
    end
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_first_line(phase_cfg[ph]);
      // the new first line takes effect at the next end of input
      send_eof();
      count = 0;
      while (count < PHASE_ITEMS) send_fragment(count);
      send_eof();
      settle();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
